// File: rtl/crm3_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// crm3_pkg
// Shared types, widths and the cofactor index table of the 3x3 solver.
// ============================================================================
package crm3_pkg;

    // Fractional bits of the fixed-point words.
    localparam int FRAC_BITS = 16;

    // Field and datapath widths.
    localparam int DATA_W = 32;
    localparam int OPD_W  = DATA_W + 1;          // multiplier operand
    localparam int PROD_W = 2 * OPD_W;           // registered product
    localparam int COF_W  = 2 * DATA_W + 2;      // cofactor, exact
    localparam int LIMB_W = 3 * DATA_W;          // cofactor split into limbs
    localparam int ACC_W  = 128;                 // accumulator and divider
    localparam int CNT_W  = $clog2(ACC_W);

    // Request codes.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COF,
        ST_DOT,
        ST_CHK,
        ST_DPREP,
        ST_DSHIFT,
        ST_DIV,
        ST_DFIN
    } t_state;

    // Pair of matrix indices for one product of a cofactor.
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
    } t_cof_pair;

    // Cofactor k is m[p]*m[q] - m[r]*m[s]; term 0 gives (p,q), term 1 (r,s).
    function automatic t_cof_pair cof_idx(input logic [3:0] k, input logic t);
        t_cof_pair r;
        r = '0;
        case ({k, t})
            5'd0:  r = '{4'd4, 4'd8};
            5'd1:  r = '{4'd7, 4'd5};
            5'd2:  r = '{4'd7, 4'd2};
            5'd3:  r = '{4'd1, 4'd8};
            5'd4:  r = '{4'd1, 4'd5};
            5'd5:  r = '{4'd4, 4'd2};
            5'd6:  r = '{4'd6, 4'd5};
            5'd7:  r = '{4'd3, 4'd8};
            5'd8:  r = '{4'd0, 4'd8};
            5'd9:  r = '{4'd6, 4'd2};
            5'd10: r = '{4'd3, 4'd2};
            5'd11: r = '{4'd0, 4'd5};
            5'd12: r = '{4'd3, 4'd7};
            5'd13: r = '{4'd6, 4'd4};
            5'd14: r = '{4'd6, 4'd1};
            5'd15: r = '{4'd0, 4'd7};
            5'd16: r = '{4'd0, 4'd4};
            5'd17: r = '{4'd3, 4'd1};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/cramer_3x3_linear_solver_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// cramer_3x3_linear_solver_unit
// 3x3 linear system solver by Cramer's rule, signed fixed point, saturated.
// ============================================================================
// Clear and load items are taken while idle, as is a solve item once the
// answer has been worked out since the last clear. The first solve item after
// a clear runs the sequencer: 18 cofactor products and 36 limb products of the
// four dot products go through one shared 33x33 multiplier in operand,
// product and accumulate steps. The check state then tests the determinant,
// and each of the three unknowns then goes through the restoring divider,
// one quotient bit a cycle. The input is stalled while the sequencer runs.
module cramer_3x3_linear_solver_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_req_type,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_rhs_value,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_coef_first,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_coef_second,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_coef_third,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [crm3_pkg::DATA_W-1:0] o_x_value,
    output logic signed [crm3_pkg::DATA_W-1:0] o_y_value,
    output logic signed [crm3_pkg::DATA_W-1:0] o_z_value,
    output logic                              o_singular
);
    import crm3_pkg::*;

    // Stored system and intermediate results.
    logic signed [DATA_W-1:0] r_mat [9];
    logic signed [DATA_W-1:0] r_rhs [3];
    logic signed [COF_W-1:0]  r_cof [9];
    logic signed [ACC_W-1:0]  r_num [3];
    logic signed [ACC_W-1:0]  r_det;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DATA_W-1:0]        r_sol [3];
    logic                     r_sing;
    logic [1:0]               r_rows_loaded;
    logic                     r_solved;

    // Sequencer.
    t_state r_state, n_state;
    logic [1:0] r_sub;
    logic [3:0] r_k;
    logic       r_t;
    logic [1:0] r_j, r_i, r_l, r_u;
    logic [CNT_W-1:0] r_cnt;

    // Shared multiplier.
    logic signed [OPD_W-1:0]  r_opa, r_opb;
    logic signed [PROD_W-1:0] r_prod;

    // Divider.
    logic [ACC_W-1:0] r_dn, r_dd;
    logic [ACC_W:0]   r_rem;
    logic             r_neg;

    // Output register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_x, r_out_y, r_out_z;
    logic              r_out_sing;

    logic w_in_acc;
    logic w_mac_last;
    t_cof_pair w_pair;
    logic [3:0] w_mat_idx;
    logic [3:0] w_cof_sel;
    logic [LIMB_W-1:0] w_cof_ext;
    logic signed [OPD_W-1:0] w_limb;
    logic signed [ACC_W-1:0] w_term, w_acc_next;
    logic w_sub_term, w_clear;
    logic signed [ACC_W-1:0] w_num_sel;
    logic [ACC_W:0] w_rem_sh;
    logic w_ge;
    logic [DATA_W-1:0] w_sat;

    assign o_stall = (r_state != ST_IDLE) || (r_out_valid && i_stall);
    assign w_in_acc = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_x_value = r_out_x;
    assign o_y_value = r_out_y;
    assign o_z_value = r_out_z;
    assign o_singular = r_out_sing;

    // Operand selection for the current product.
    always_comb begin
        w_pair = cof_idx(r_k, r_t);
        w_cof_sel = 4'((r_j == 2'd0) ? 2'd0 : 2'(r_j - 2'd1)) * 4'd3 + 4'(r_i);
        if (r_state == ST_COF) begin
            w_mat_idx = (r_sub == 2'd0) ? w_pair.a : w_pair.b;
        end else begin
            w_mat_idx = 4'(r_i) * 4'd3;
        end
        w_cof_ext = LIMB_W'(r_cof[w_cof_sel]);
        case (r_l)
            2'd0: w_limb = {1'b0, w_cof_ext[DATA_W-1:0]};
            2'd1: w_limb = {1'b0, w_cof_ext[2*DATA_W-1:DATA_W]};
            default: w_limb = {w_cof_ext[LIMB_W-1], w_cof_ext[LIMB_W-1:2*DATA_W]};
        endcase
    end

    // Accumulate step: limb shift in dot products, cofactor term 1 subtracted.
    always_comb begin
        w_term = ACC_W'(r_prod);
        if (r_state == ST_DOT) begin
            case (r_l)
                2'd0: w_term = ACC_W'(r_prod);
                2'd1: w_term = ACC_W'(r_prod) <<< DATA_W;
                default: w_term = ACC_W'(r_prod) <<< (2 * DATA_W);
            endcase
        end
        w_sub_term = (r_state == ST_COF) && r_t;
        w_clear = (r_state == ST_COF) ? !r_t : (r_i == 2'd0 && r_l == 2'd0);
        if (w_clear) begin
            w_acc_next = w_sub_term ? -w_term : w_term;
        end else begin
            w_acc_next = w_sub_term ? r_acc - w_term : r_acc + w_term;
        end
        w_mac_last = (r_state == ST_COF) ? (r_t && r_k == 4'd8)
                   : (r_l == 2'd2 && r_i == 2'd2 && r_j == 2'd3);
    end

    // Divider step and saturation of the quotient.
    always_comb begin
        w_num_sel = r_num[r_u];
        w_rem_sh = {r_rem[ACC_W-1:0], r_dn[ACC_W-1]};
        w_ge = w_rem_sh >= {1'b0, r_dd};
        if (r_neg) begin
            w_sat = (r_dn > ACC_W'(33'h080000000)) ? 32'h80000000
                  : DATA_W'(-r_dn);
        end else begin
            w_sat = (r_dn > ACC_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : r_dn[DATA_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_req_type != REQ_CLEAR && i_req_type != REQ_LOAD
                        && !r_solved) begin
                    n_state = ST_COF;
                end
            end
            ST_COF: begin
                if (r_sub == 2'd3 && w_mac_last) n_state = ST_DOT;
            end
            ST_DOT: begin
                if (r_sub == 2'd3 && w_mac_last) n_state = ST_CHK;
            end
            ST_CHK:    n_state = (r_det == '0) ? ST_IDLE : ST_DPREP;
            ST_DPREP:  n_state = ST_DSHIFT;
            ST_DSHIFT: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(ACC_W - 1)) n_state = ST_DFIN;
            end
            ST_DFIN:   n_state = (r_u == 2'd2) ? ST_IDLE : ST_DPREP;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers: row count, solved flag, output valid, counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_loaded <= '0;
            r_solved <= 1'b0;
            r_out_valid <= 1'b0;
            r_sing <= 1'b0;
            r_sub <= '0;
            r_k <= '0;
            r_t <= 1'b0;
            r_j <= '0;
            r_i <= '0;
            r_l <= '0;
            r_u <= '0;
            r_cnt <= '0;
            for (int e = 0; e < 9; e++) r_mat[e] <= '0;
            for (int e = 0; e < 3; e++) r_sol[e] <= '0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (i_req_type)
                            REQ_CLEAR: begin
                                for (int e = 0; e < 9; e++) r_mat[e] <= '0;
                                r_rows_loaded <= '0;
                                r_solved <= 1'b0;
                            end
                            REQ_LOAD: begin
                                if (r_rows_loaded != 2'd3) begin
                                    r_mat[4'(r_rows_loaded) * 4'd3] <= i_coef_first;
                                    r_mat[4'(r_rows_loaded) * 4'd3 + 4'd1] <= i_coef_second;
                                    r_mat[4'(r_rows_loaded) * 4'd3 + 4'd2] <= i_coef_third;
                                    r_rows_loaded <= r_rows_loaded + 2'd1;
                                end
                            end
                            default: begin
                                if (r_solved) begin
                                    r_out_valid <= 1'b1;
                                end
                            end
                        endcase
                        r_sub <= '0;
                        r_k <= '0;
                        r_t <= 1'b0;
                    end
                end
                ST_COF: begin
                    r_sub <= r_sub + 2'd1;
                    if (r_sub == 2'd3) begin
                        r_t <= !r_t;
                        if (r_t) r_k <= r_k + 4'd1;
                        if (w_mac_last) begin
                            r_j <= '0;
                            r_i <= '0;
                            r_l <= '0;
                        end
                    end
                end
                ST_DOT: begin
                    r_sub <= r_sub + 2'd1;
                    if (r_sub == 2'd3) begin
                        if (r_l == 2'd2) begin
                            r_l <= '0;
                            if (r_i == 2'd2) begin
                                r_i <= '0;
                                r_j <= r_j + 2'd1;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_l <= r_l + 2'd1;
                        end
                    end
                end
                ST_CHK: begin
                    r_u <= '0;
                    if (r_det == '0) begin
                        r_sing <= 1'b1;
                        for (int e = 0; e < 3; e++) r_sol[e] <= '0;
                        r_solved <= 1'b1;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_sing <= 1'b0;
                    end
                end
                ST_DSHIFT: r_cnt <= '0;
                ST_DIV:    r_cnt <= r_cnt + CNT_W'(1);
                ST_DFIN: begin
                    r_sol[r_u] <= w_sat;
                    r_u <= r_u + 2'd1;
                    if (r_u == 2'd2) begin
                        r_solved <= 1'b1;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers: right-hand sides, multiplier, accumulator, divider.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_req_type == REQ_LOAD && r_rows_loaded != 2'd3) begin
                    r_rhs[r_rows_loaded] <= i_rhs_value;
                end
                if (w_in_acc && i_req_type != REQ_CLEAR && i_req_type != REQ_LOAD) begin
                    r_out_x <= r_sol[0];
                    r_out_y <= r_sol[1];
                    r_out_z <= r_sol[2];
                    r_out_sing <= r_sing;
                end
            end
            ST_COF, ST_DOT: begin
                case (r_sub)
                    2'd0: begin
                        r_opa <= (r_state == ST_COF) ? OPD_W'(r_mat[w_mat_idx]) : w_limb;
                    end
                    2'd1: begin
                        if (r_state == ST_DOT && r_j != 2'd0) begin
                            r_opb <= OPD_W'(r_rhs[r_i]);
                        end else begin
                            r_opb <= OPD_W'(r_mat[w_mat_idx]);
                        end
                    end
                    2'd2: r_prod <= r_opa * r_opb;
                    default: begin
                        r_acc <= w_acc_next;
                        if (r_state == ST_COF && r_t) begin
                            r_cof[r_k] <= w_acc_next[COF_W-1:0];
                        end
                        if (r_state == ST_DOT && r_l == 2'd2 && r_i == 2'd2) begin
                            if (r_j == 2'd0) r_det <= w_acc_next;
                            else r_num[2'(r_j - 2'd1)] <= w_acc_next;
                        end
                    end
                endcase
            end
            ST_DPREP: begin
                r_dn <= (w_num_sel < 0) ? ACC_W'(-w_num_sel) : ACC_W'(w_num_sel);
                r_dd <= ((r_det < 0) ? ACC_W'(-r_det) : ACC_W'(r_det)) << 1;
                r_neg <= w_num_sel[ACC_W-1] ^ r_det[ACC_W-1];
            end
            ST_DSHIFT: begin
                r_dn <= (r_dn << (FRAC_BITS + 1)) + {1'b0, r_dd[ACC_W-1:1]};
                r_rem <= '0;
            end
            ST_DIV: begin
                r_rem <= w_ge ? w_rem_sh - {1'b0, r_dd} : w_rem_sh;
                r_dn <= {r_dn[ACC_W-2:0], w_ge};
            end
            ST_CHK: begin
                if (r_det == '0) begin
                    r_out_x <= '0;
                    r_out_y <= '0;
                    r_out_z <= '0;
                    r_out_sing <= 1'b1;
                end
            end
            ST_DFIN: begin
                if (r_u == 2'd2) begin
                    r_out_x <= r_sol[0];
                    r_out_y <= r_sol[1];
                    r_out_z <= w_sat;
                    r_out_sing <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // A singular answer always reports zero unknowns.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sing) |-> (r_out_x == '0 && r_out_y == '0 && r_out_z == '0))
        else $error("singular result with nonzero unknowns");

    // The divider remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < {1'b0, r_dd}))
        else $error("divider remainder out of range");

    // No result is pending while the products are being formed.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COF || r_state == ST_DOT) |-> !r_out_valid)
        else $error("result pending during solve");

    // The sequencer starts only on an accepted solve item.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COF && $past(r_state) == ST_IDLE)
            |-> $past(w_in_acc && i_req_type != REQ_CLEAR && i_req_type != REQ_LOAD))
        else $error("solve started without a request");

endmodule

// File: tb/sv/crm3_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// crm3_checker
// Watches both channels of the 3x3 solver, predicts each answer and compares.
// ============================================================================
// Every accepted input item updates a private copy of the solver state. A
// solve item queues the predicted answer, and each accepted result is checked
// field by field against the oldest queued answer.
module crm3_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_in_stall,
    input  logic [1:0]                        i_req_type,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_rhs_value,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_coef_first,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_coef_second,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_coef_third,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_x_value,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_y_value,
    input  logic signed [crm3_pkg::DATA_W-1:0] i_z_value,
    input  logic                              i_singular,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_answers,
    output int                                o_singulars
);
    import crm3_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sing;
    } t_answer;

    // Private copy of the solver state.
    logic signed [31:0] mat [9];
    logic signed [31:0] rhs [3];
    int                 rows;
    logic               solved;
    t_answer            kept;
    t_answer            answer_q [$];

    // Exact 2x2 minor m[p]*m[q] - m[r]*m[s].
    function automatic logic signed [127:0] minor2(int p, int q, int r, int s);
        logic signed [127:0] a;
        logic signed [127:0] b;
        a = 128'(mat[p]) * 128'(mat[q]);
        b = 128'(mat[r]) * 128'(mat[s]);
        return a - b;
    endfunction

    // Rounded, saturated num * 2^FRAC_BITS / den with ties away from zero.
    function automatic logic signed [31:0] fixed_div(logic signed [127:0] num,
                                                    logic signed [127:0] den);
        logic        neg;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = ((n << (FRAC_BITS + 1)) + d) / (d << 1);
        if (neg) begin
            if (q > 128'h8000_0000) return 32'sh8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return q[31:0];
    endfunction

    // Work out the answer of the current system.
    function automatic t_answer solve_system();
        t_answer a;
        logic signed [127:0] c [9];
        logic signed [127:0] det;
        logic signed [127:0] r0, r1, r2;
        c[0] = minor2(4, 8, 7, 5); c[1] = minor2(7, 2, 1, 8); c[2] = minor2(1, 5, 4, 2);
        c[3] = minor2(6, 5, 3, 8); c[4] = minor2(0, 8, 6, 2); c[5] = minor2(3, 2, 0, 5);
        c[6] = minor2(3, 7, 6, 4); c[7] = minor2(6, 1, 0, 7); c[8] = minor2(0, 4, 3, 1);
        det = c[0] * 128'(mat[0]) + c[1] * 128'(mat[3]) + c[2] * 128'(mat[6]);
        a = '{32'sd0, 32'sd0, 32'sd0, 1'b1};
        if (det != 0) begin
            r0 = 128'(rhs[0]); r1 = 128'(rhs[1]); r2 = 128'(rhs[2]);
            a.x = fixed_div(c[0] * r0 + c[1] * r1 + c[2] * r2, det);
            a.y = fixed_div(c[3] * r0 + c[4] * r1 + c[5] * r2, det);
            a.z = fixed_div(c[6] * r0 + c[7] * r1 + c[8] * r2, det);
            a.sing = 1'b0;
        end
        return a;
    endfunction

    assign o_pending = answer_q.size();

    // Predict on accepted input items and check accepted results.
    always @(posedge i_clk) begin
        t_answer e;
        if (!i_rst_n) begin
            foreach (mat[i]) mat[i] <= '0;
            foreach (rhs[i]) rhs[i] <= '0;
            rows     <= 0;
            solved   <= 1'b0;
            kept     <= '{32'sd0, 32'sd0, 32'sd0, 1'b0};
            o_errors <= 0;
            o_answers <= 0;
            o_singulars <= 0;
        end else begin
            if (i_valid && !i_in_stall) begin
                if (i_req_type == REQ_CLEAR) begin
                    foreach (mat[i]) mat[i] = '0;
                    rows = 0;
                    solved = 1'b0;
                end else if (i_req_type == REQ_LOAD) begin
                    if (rows < 3) begin
                        rhs[rows] = i_rhs_value;
                        mat[rows * 3] = i_coef_first;
                        mat[rows * 3 + 1] = i_coef_second;
                        mat[rows * 3 + 2] = i_coef_third;
                        rows = rows + 1;
                    end
                end else begin
                    if (!solved) begin
                        kept = solve_system();
                        solved = 1'b1;
                    end
                    answer_q.push_back(kept);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h z=%h singular=%b",
                             $time, i_x_value, i_y_value, i_z_value, i_singular);
                    o_errors <= o_errors + 1;
                end else begin
                    e = answer_q.pop_front();
                    o_answers <= o_answers + 1;
                    if (e.sing) o_singulars <= o_singulars + 1;
                    if (e.x !== i_x_value || e.y !== i_y_value || e.z !== i_z_value
                        || e.sing !== i_singular) begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h singular=%b",
                                 $time, e.x, e.y, e.z, e.sing);
                        $display("%0t:          actual   x=%h y=%h z=%h singular=%b",
                                 $time, i_x_value, i_y_value, i_z_value, i_singular);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_cramer_3x3_linear_solver_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_cramer_3x3_linear_solver_unit
// Stimulus and verdict for the 3x3 Cramer's rule solver.
// ============================================================================
// A directed part covers extreme coefficients, singular and short systems,
// request code three, surplus rows and loads after a solve. The random part
// mostly sends clear, three loads and solves with random content, plus noise.
module tb_cramer_3x3_linear_solver_unit;
    import crm3_pkg::*;

    localparam logic [1:0] REQ_SOLVE = 2'd2;
    localparam logic [1:0] REQ_ALT   = 2'd3;
    localparam int         IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = REQ_CLEAR;
    logic signed [31:0] i_rhs_value = '0;
    logic signed [31:0] i_coef_first = '0;
    logic signed [31:0] i_coef_second = '0;
    logic signed [31:0] i_coef_third = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_x_value, o_y_value, o_z_value;
    logic        o_singular;
    int          errors, pending, answers, singulars;
    int          sent = 0;
    int          quiet = 0;
    int          stall_left = 0;
    logic        stim_done = 1'b0;

    always #6 i_clk = ~i_clk;

    cramer_3x3_linear_solver_unit DUT (.*);

    crm3_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_req_type, .i_rhs_value,
        .i_coef_first, .i_coef_second, .i_coef_third, .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_x_value(o_x_value), .i_y_value(o_y_value),
        .i_z_value(o_z_value), .i_singular(o_singular), .o_errors(errors),
        .o_pending(pending), .o_answers(answers), .o_singulars(singulars)
    );

    // Gap length: mostly short, sometimes long.
    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    // Coefficient value, weighted toward extremes and small numbers.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
            3: return $urandom_range(0, 255);
            4: return 32'(int'($urandom_range(0, 2000)) - 1000) << 12;
            default: return $urandom();
        endcase
    endfunction

    // Send one item and wait until it is accepted. Valid drops only for a gap.
    task automatic send(logic [1:0] req, logic [31:0] r, logic [31:0] a,
                        logic [31:0] b, logic [31:0] c);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_rhs_value <= r;
        i_coef_first <= a;
        i_coef_second <= b;
        i_coef_third <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic load_row();
        send(REQ_LOAD, rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    // Output stall pattern: runs of stalled cycles, mostly short, a few long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left <= gap_len();
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT && !(stim_done && pending == 0)) begin
            $display("cramer_3x3_linear_solver_unit test failed");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Solve right after reset, then a simple identity system.
        send(REQ_SOLVE, '0, '0, '0, '0);
        send(REQ_LOAD, 32'h0001_0000, 32'h0001_0000, '0, '0);
        send(REQ_SOLVE, '0, '0, '0, '0);
        send(REQ_LOAD, 32'hFFFF_0000, '0, 32'h0001_0000, '0);
        send(REQ_LOAD, 32'h7FFF_FFFF, '0, '0, 32'h0001_0000);
        send(REQ_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(REQ_ALT, '0, '0, '0, '0);
        send(REQ_SOLVE, '0, '0, '0, '0);
        // Extreme coefficients with a tiny determinant: saturation.
        send(REQ_CLEAR, '0, '0, '0, '0);
        send(REQ_LOAD, 32'h7FFF_FFFF, 32'h0000_0001, '0, '0);
        send(REQ_LOAD, 32'h8000_0000, '0, 32'h0000_0001, '0);
        send(REQ_LOAD, 32'h8000_0000, '0, '0, 32'hFFFF_FFFF);
        send(REQ_SOLVE, '0, '0, '0, '0);
        // All extremes, singular by repeated rows.
        send(REQ_CLEAR, '0, '0, '0, '0);
        send(REQ_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send(REQ_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send(REQ_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send(REQ_SOLVE, '0, '0, '0, '0);
        send(REQ_CLEAR, '0, '0, '0, '0);
        send(REQ_LOAD, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        send(REQ_LOAD, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send(REQ_SOLVE, '0, '0, '0, '0);

        // Random part: mostly whole systems, some broken sequences and noise.
        while (sent < 1400) begin
            case ($urandom_range(0, 9))
                0: send(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                        $urandom());
                1: begin
                    send(REQ_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
                    n = $urandom_range(0, 5);
                    repeat (n) load_row();
                    send(2'($urandom_range(2, 3)), $urandom(), $urandom(), $urandom(),
                         $urandom());
                end
                default: begin
                    send(REQ_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
                    repeat (3) load_row();
                    n = $urandom_range(1, 3);
                    repeat (n) send(2'($urandom_range(2, 3)), $urandom(), $urandom(),
                                    $urandom(), $urandom());
                end
            endcase
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;

        n = 0;
        while (pending != 0 && n < IDLE_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (700) @(posedge i_clk);
        $display("Sent %0d input items; %0d answers checked, %0d of them singular.",
                 sent, answers, singulars);
        if (errors == 0 && pending == 0)
            $display("cramer_3x3_linear_solver_unit test passed");
        else
            $display("cramer_3x3_linear_solver_unit test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/crm3_pkg.sv
rtl/cramer_3x3_linear_solver_unit.sv
tb/sv/crm3_checker.sv
tb/sv/tb_cramer_3x3_linear_solver_unit.sv
